// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and reset.
`define CHK_ASSERT_CR(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Same, on the usual clock and reset names.
`define CHK_ASSERT(label, prop) `CHK_ASSERT_CR(label, clock, reset, prop)

`endif

// ----- sv/prrt_pkg.sv -----
package prrt_pkg;

   localparam int RANKS_DEFAULT = 64;
   localparam int STAMP_W       = 64;
   localparam int COUNT_W       = 32;
   localparam int CSR_W         = 7;

   localparam logic [CSR_W-1:0] RANK_COUNT_RESET = 7'd64;

   localparam logic [1:0] ACT_ENTRY = 2'd0;
   localparam logic [1:0] ACT_EXIT  = 2'd1;

   localparam logic [STAMP_W-1:0] SIGN64 = 64'h8000_0000_0000_0000;
   localparam logic [STAMP_W-1:0] MAXS64 = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_RANK = 2'd1,
      ST_REENTRY  = 2'd2,
      ST_NO_ENTRY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_LOAD = 3'b010,
      S_CALC = 3'b100
   } state_type;

   // One table row.
   typedef struct packed {
      logic [STAMP_W-1:0] entry_stamp;
      logic               active;
      logic [STAMP_W-1:0] last_dur;
      logic [STAMP_W-1:0] sum_dur;
      logic [COUNT_W-1:0] done_cnt;
   } entry_type;

endpackage

// ----- sv/prrt_table.sv -----
module prrt_table
   import prrt_pkg::*;
#(
   parameter int RANKS = RANKS_DEFAULT,
   parameter int IDX_W = (RANKS > 1) ? $clog2(RANKS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data
);

   entry_type        mem [RANKS];
   entry_type        rd_q_ff;
   logic             rd_vld_ff;
   logic [RANKS-1:0] vld_ff;

   // row data, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff   <= mem[rd_addr];
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   // written-since-reset flags; an unwritten row reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

// ----- sv/per_rank_region_runtime_tracker_top.sv -----
// Channel   | Ports                                      | Handshake
// ----------+--------------------------------------------+---------------------------
// request   | req_action, req_rank, req_timestamp        | start & !busy
// response  | rsp_status, rsp_last_span, rsp_span_total, | rsp_strobe, one cycle,
//           | rsp_completions, rsp_in_region             | no back-pressure
// csr       | csr_data (rank_count)                      | csr_valid & csr_ready
//
// Steps per word: the registered table read, the duration stage and the
// total/write-back stage (accept, load, calc); busy blocks a new word until
// calc is done. The response strobe rises in the cycle after calc, when busy is low again.
// Reset: synchronous; clears the FSM, the response strobe, rank_count (to 64)
// and the per-row written flags, so every row reads as zero with no sweep.
// The receiver cannot stall; every accepted word gives exactly one response.
module per_rank_region_runtime_tracker_top
   import prrt_pkg::*;
#(
   parameter int RANKS = RANKS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // request
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_action,
   input  logic [7:0]                req_rank,
   input  logic [STAMP_W-1:0]        req_timestamp,
   // response
   output logic                      rsp_strobe,
   output logic [1:0]                rsp_status,
   output logic signed [STAMP_W-1:0] rsp_last_span,
   output logic signed [STAMP_W-1:0] rsp_span_total,
   output logic [COUNT_W-1:0]        rsp_completions,
   output logic                      rsp_in_region,
   // configuration
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_W-1:0]          csr_data
);

   localparam int         IDX_W   = (RANKS > 1) ? $clog2(RANKS) : 1;
   localparam logic [8:0] RANKS_L = 9'(RANKS);

   state_type state_ff, state_in;

   logic [CSR_W-1:0] rank_count_ff;

   // request word held for the whole operation
   logic [1:0]         act_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic               bad_ff;

   // stage registers
   entry_type          ent_ff;
   logic [STAMP_W-1:0] dur_ff;

   // response registers
   logic               rsp_strobe_ff;
   status_type         rsp_status_ff;
   entry_type          rsp_ent_ff;

   logic               accept;
   logic [8:0]         limit;
   logic               bad_rank;
   entry_type          rd_data;
   logic [STAMP_W:0]   diff_wide;
   logic [STAMP_W-1:0] dur_sat;
   logic [STAMP_W-1:0] sum_raw;
   logic [STAMP_W-1:0] sum_sat;
   logic [COUNT_W-1:0] cnt_inc;
   entry_type          new_ent;
   status_type         new_status;
   logic               wr_en;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // effective rank count: min(rank_count, RANKS)
   assign limit    = ({2'b00, rank_count_ff} < RANKS_L) ? {2'b00, rank_count_ff} : RANKS_L;
   assign bad_rank = ({1'b0, req_rank} >= limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_count_ff <= RANK_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         rank_count_ff <= csr_data;
      end
   end

   // ---------------- FSM ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD:  state_in = S_CALC;
         S_CALC:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff   <= req_action;
         idx_ff   <= req_rank[IDX_W-1:0];
         stamp_ff <= req_timestamp;
         bad_ff   <= bad_rank;
      end
   end

   // ---------------- table ----------------
   prrt_table #(
      .RANKS (RANKS),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && !bad_rank),
      .rd_addr (req_rank[IDX_W-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (new_ent)
   );

   // ---------------- load stage: duration ----------------
   // exit - entry in 65 bits; top two bits disagreeing means out of int64 range
   assign diff_wide = {1'b0, stamp_ff} - {1'b0, rd_data.entry_stamp};

   always_comb begin
      if (!diff_wide[STAMP_W] && diff_wide[STAMP_W-1]) begin
         dur_sat = MAXS64;
      end else if (diff_wide[STAMP_W] && !diff_wide[STAMP_W-1]) begin
         dur_sat = SIGN64;
      end else begin
         dur_sat = diff_wide[STAMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LOAD) begin
         ent_ff <= rd_data;
         dur_ff <= dur_sat;
      end
   end

   // ---------------- calc stage: total, count, write back ----------------
   assign sum_raw = ent_ff.sum_dur + dur_ff;

   always_comb begin
      if ((ent_ff.sum_dur[STAMP_W-1] == dur_ff[STAMP_W-1]) &&
          (sum_raw[STAMP_W-1] != ent_ff.sum_dur[STAMP_W-1])) begin
         sum_sat = ent_ff.sum_dur[STAMP_W-1] ? SIGN64 : MAXS64;
      end else begin
         sum_sat = sum_raw;
      end
   end

   assign cnt_inc = (&ent_ff.done_cnt) ? ent_ff.done_cnt : ent_ff.done_cnt + 1'b1;

   always_comb begin
      new_ent    = ent_ff;
      new_status = ST_OK;
      wr_en      = 1'b0;
      if (bad_ff) begin
         new_ent    = '0;
         new_status = ST_BAD_RANK;
      end else begin
         case (act_ff)
            ACT_ENTRY: begin
               if (ent_ff.active) begin
                  new_status = ST_REENTRY;
               end else begin
                  new_ent.entry_stamp = stamp_ff;
                  new_ent.active      = 1'b1;
                  wr_en               = (state_ff == S_CALC);
               end
            end
            ACT_EXIT: begin
               if (!ent_ff.active) begin
                  new_status = ST_NO_ENTRY;
               end else begin
                  new_ent.entry_stamp = '0;
                  new_ent.active      = 1'b0;
                  new_ent.last_dur    = dur_ff;
                  new_ent.sum_dur     = sum_sat;
                  new_ent.done_cnt    = cnt_inc;
                  wr_en               = (state_ff == S_CALC);
               end
            end
            default: begin
               // read, and the unused code behaves as read
            end
         endcase
      end
   end

   // ---------------- response ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == S_CALC);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CALC) begin
         rsp_status_ff <= new_status;
         rsp_ent_ff    <= new_ent;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_span   = $signed(rsp_ent_ff.last_dur);
   assign rsp_span_total  = $signed(rsp_ent_ff.sum_dur);
   assign rsp_completions = rsp_ent_ff.done_cnt;
   assign rsp_in_region   = rsp_ent_ff.active;

endmodule

// ----- sv/prrt_checker.sv -----
`include "assert_macros.svh"

module prrt_checker
   import prrt_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_strobe,
   input logic [1:0]                rsp_status,
   input logic signed [STAMP_W-1:0] rsp_last_span,
   input logic signed [STAMP_W-1:0] rsp_span_total,
   input logic [COUNT_W-1:0]        rsp_completions,
   input logic                      rsp_in_region
);

   logic stats_zero;

   assign stats_zero = (rsp_completions == '0) && !rsp_in_region &&
                       (rsp_last_span == '0) && (rsp_span_total == '0);

   // an accepted word blocks further requests
   `CHK_ASSERT(a_accept_busy, (start && !busy) |=> busy)

   // response strobe after accept, once the load and calc states have passed
   `CHK_ASSERT(a_rsp_latency, (start && !busy) |-> ##3 rsp_strobe)

   // one response per word, never back to back
   `CHK_ASSERT(a_strobe_single, rsp_strobe |=> !rsp_strobe)

   // rejected rank reports all-zero statistics
   `CHK_ASSERT(a_bad_rank_zero, (rsp_strobe && rsp_status == ST_BAD_RANK) |-> stats_zero)

endmodule

bind per_rank_region_runtime_tracker_top prrt_checker u_prrt_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_last_span   (rsp_last_span),
   .rsp_span_total  (rsp_span_total),
   .rsp_completions (rsp_completions),
   .rsp_in_region   (rsp_in_region)
);

// ----- tb/sv/per_rank_region_runtime_tracker_top_test.sv -----
module per_rank_region_runtime_tracker_top_test
   import prrt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANKS = RANKS_DEFAULT;

   // Action codes the package leaves out; code 3 is unused and reads.
   localparam logic [1:0] ACT_READ   = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Run guard: far above the slowest legal run (about 1400 words plus
   // sender gaps, config writes and drains).
   localparam int CYCLE_LIMIT = 400000;
   // Quiet time after the last owed response, with a little padding.
   localparam int SETTLE_CYCLES = 8;

   // One response word.
   typedef struct packed {
      status_type         status;
      logic [STAMP_W-1:0] last_rt;
      logic [STAMP_W-1:0] total_rt;
      logic [COUNT_W-1:0] completions;
      logic               in_region;
   } region_stats_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   // One line of the directed plan. A row either carries a request word or
   // a rank_count write; a word row with known_result set carries its own
   // hand-written response, otherwise the tracker model supplies it.
   typedef struct {
      row_kind_type       kind;
      logic [1:0]         action;
      logic [7:0]         rank;
      logic [STAMP_W-1:0] stamp;
      bit                 known_result;
      region_stats_type   result;
      logic [CSR_W-1:0]   csr_value;
   } plan_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [1:0]                req_action = '0;
   logic [7:0]                req_rank = '0;
   logic [STAMP_W-1:0]        req_timestamp = '0;
   logic                      rsp_strobe;
   logic [1:0]                rsp_status;
   logic signed [STAMP_W-1:0] rsp_last_span;
   logic signed [STAMP_W-1:0] rsp_span_total;
   logic [COUNT_W-1:0]        rsp_completions;
   logic                      rsp_in_region;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_W-1:0]          csr_data = '0;

   per_rank_region_runtime_tracker_top #(
      .RANKS(RANKS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_rank(req_rank),
      .req_timestamp(req_timestamp),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_last_span(rsp_last_span),
      .rsp_span_total(rsp_span_total),
      .rsp_completions(rsp_completions),
      .rsp_in_region(rsp_in_region),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Tracker model: its own copy of the rank table and of rank_count.
   // ---------------------------------------------------------------------
   logic [STAMP_W-1:0] trk_entry  [RANKS];
   logic               trk_active [RANKS];
   logic [STAMP_W-1:0] trk_last   [RANKS];
   logic [STAMP_W-1:0] trk_total  [RANKS];
   logic [COUNT_W-1:0] trk_count  [RANKS];
   logic [CSR_W-1:0]   trk_rank_count;

   region_stats_type pending_stats[$];   // responses still owed, oldest first
   int unsigned      fail_count = 0;
   int unsigned      cycle_count = 0;

   // What the word on the request ports should give; set with the word.
   bit               cur_known = 1'b0;
   region_stats_type cur_result;

   bit idle_on = 1'b1;

   function automatic void clear_tracker();
      for (int i = 0; i < RANKS; i++) begin
         trk_entry[i]  = '0;
         trk_active[i] = 1'b0;
         trk_last[i]   = '0;
         trk_total[i]  = '0;
         trk_count[i]  = '0;
      end
      trk_rank_count = RANK_COUNT_RESET;
   endfunction

   // Signed exit - entry, clamped to the int64 range.
   function automatic logic [STAMP_W-1:0] span_ticks(input logic [STAMP_W-1:0] entry,
                                                     input logic [STAMP_W-1:0] leave);
      logic [STAMP_W-1:0] d;
      if (leave >= entry) begin
         d = leave - entry;
         return (d > MAXS64) ? MAXS64 : d;
      end
      d = entry - leave;
      if (d >= SIGN64)
         return SIGN64;
      return -d;
   endfunction

   // Two's complement add that sticks at the int64 limits.
   function automatic logic [STAMP_W-1:0] add_clamped(input logic [STAMP_W-1:0] a,
                                                      input logic [STAMP_W-1:0] b);
      logic [STAMP_W-1:0] r;
      r = a + b;
      if (a[STAMP_W-1] == b[STAMP_W-1] && r[STAMP_W-1] != a[STAMP_W-1])
         return a[STAMP_W-1] ? SIGN64 : MAXS64;
      return r;
   endfunction

   function automatic int unsigned ranks_in_use();
      return (trk_rank_count < RANKS) ? int'(trk_rank_count) : RANKS;
   endfunction

   // Applies one region event to the model table and returns the response.
   function automatic region_stats_type apply_region_event(input logic [1:0] act,
                                                           input logic [7:0] rk,
                                                           input logic [STAMP_W-1:0] ts);
      region_stats_type r;
      r = '0;
      if (rk >= ranks_in_use()) begin
         r.status = ST_BAD_RANK;
         return r;
      end
      r.status = ST_OK;
      case (act)
         ACT_ENTRY: begin
            if (trk_active[rk]) begin
               r.status = ST_REENTRY;       // keep the first entry time
            end else begin
               trk_entry[rk]  = ts;
               trk_active[rk] = 1'b1;
            end
         end
         ACT_EXIT: begin
            if (!trk_active[rk]) begin
               r.status = ST_NO_ENTRY;
            end else begin
               trk_last[rk]  = span_ticks(trk_entry[rk], ts);
               trk_total[rk] = add_clamped(trk_total[rk], trk_last[rk]);
               if (trk_count[rk] != '1)
                  trk_count[rk] = trk_count[rk] + 1'b1;
               trk_active[rk] = 1'b0;
               trk_entry[rk]  = '0;
            end
         end
         default: ;                         // read and the unused code
      endcase
      r.last_rt     = trk_last[rk];
      r.total_rt    = trk_total[rk];
      r.completions = trk_count[rk];
      r.in_region   = trk_active[rk];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Monitor. Everything is sampled at the rising edge, before the design's
   // registers move. The response is checked before a new word is booked,
   // since a word can be taken in the same cycle that the strobe is up.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      region_stats_type want;
      region_stats_type model_says;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else if (!reset) begin
         if (rsp_strobe) begin
            if (pending_stats.size() == 0) begin
               $error("response word with nothing outstanding (status %0d)", rsp_status);
               fail_count++;
            end else begin
               want = pending_stats.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_last_span !== want.last_rt) begin
                  $error("last_span: expected %h, got %h", want.last_rt,
                         rsp_last_span);
                  fail_count++;
               end
               if (rsp_span_total !== want.total_rt) begin
                  $error("span_total: expected %h, got %h", want.total_rt,
                         rsp_span_total);
                  fail_count++;
               end
               if (rsp_completions !== want.completions) begin
                  $error("completions: expected %0d, got %0d", want.completions,
                         rsp_completions);
                  fail_count++;
               end
               if (rsp_in_region !== want.in_region) begin
                  $error("in_region: expected %0d, got %0d", want.in_region,
                         rsp_in_region);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            // The model always runs so its table stays in step; a directed
            // row with a hand-written result checks against that instead.
            model_says = apply_region_event(req_action, req_rank, req_timestamp);
            pending_stats.push_back(cur_known ? cur_result : model_says);
         end
         if (csr_valid && csr_ready)
            trk_rank_count = csr_data;
      end
   end

   // ---------------------------------------------------------------------
   // Sender side. Inputs move on the falling edge only.
   // ---------------------------------------------------------------------
   function automatic region_stats_type stats(input status_type st,
                                              input logic [STAMP_W-1:0] last_rt,
                                              input logic [STAMP_W-1:0] total_rt,
                                              input logic [COUNT_W-1:0] cnt,
                                              input logic inr);
      region_stats_type r;
      r.status      = st;
      r.last_rt     = last_rt;
      r.total_rt    = total_rt;
      r.completions = cnt;
      r.in_region   = inr;
      return r;
   endfunction

   // Random sender gap, about 9 times in a hundred.
   task automatic maybe_idle();
      if (idle_on && $urandom_range(0, 99) < 9) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
   endtask

   // Presents one word and returns at the edge that takes it. start stays
   // high for a following word; callers drop it by idling or draining.
   task automatic send_word(input logic [1:0] act, input logic [7:0] rk,
                            input logic [STAMP_W-1:0] ts, input bit known,
                            input region_stats_type result);
      maybe_idle();
      @(negedge clock);
      req_action    <= act;
      req_rank      <= rk;
      req_timestamp <= ts;
      start         <= 1'b1;
      cur_known  = known;
      cur_result = result;
      do @(posedge clock); while (busy);
   endtask

   // Stop sending and wait for every owed response, then let the pipe settle.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // rank_count write; only ever called right after a drain.
   task automatic write_rank_count(input logic [CSR_W-1:0] value);
      repeat ($urandom_range(0, 3)) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Directed plan.
   // ---------------------------------------------------------------------
   plan_row_type directed_plan[$];

   function automatic void plan_word(input logic [1:0] act, input logic [7:0] rk,
                                     input logic [STAMP_W-1:0] ts, input bit known,
                                     input region_stats_type result);
      plan_row_type row;
      row.kind         = ROW_WORD;
      row.action       = act;
      row.rank         = rk;
      row.stamp        = ts;
      row.known_result = known;
      row.result       = result;
      row.csr_value    = '0;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_csr(input logic [CSR_W-1:0] value);
      plan_row_type row;
      row = '{kind: ROW_CSR, action: '0, rank: '0, stamp: '0, known_result: 1'b0,
              result: '0, csr_value: value};
      directed_plan.push_back(row);
   endfunction

   function automatic void build_directed_plan();
      region_stats_type none;
      none = '0;
      // fresh table reads as zero at both ends of the rank range
      plan_word(ACT_READ, 8'd0, '0, 1'b1, stats(ST_OK, '0, '0, '0, 1'b0));
      plan_word(ACT_READ, 8'd63, '0, 1'b1, stats(ST_OK, '0, '0, '0, 1'b0));
      // rank out of range, including the top of the rank field
      plan_word(ACT_READ, 8'd64, '0, 1'b1, stats(ST_BAD_RANK, '0, '0, '0, 1'b0));
      plan_word(ACT_ENTRY, 8'd255, '0, 1'b1, stats(ST_BAD_RANK, '0, '0, '0, 1'b0));
      // exit with no entry
      plan_word(ACT_EXIT, 8'd5, 64'd77, 1'b1, stats(ST_NO_ENTRY, '0, '0, '0, 1'b0));
      // zero is a real entry time; a second entry keeps the first one
      plan_word(ACT_ENTRY, 8'd5, '0, 1'b1, stats(ST_OK, '0, '0, '0, 1'b1));
      plan_word(ACT_ENTRY, 8'd5, 64'd100, 1'b1, stats(ST_REENTRY, '0, '0, '0, 1'b1));
      plan_word(ACT_EXIT, 8'd5, 64'd100, 1'b1,
                stats(ST_OK, 64'd100, 64'd100, 32'd1, 1'b0));
      // unused action code reads
      plan_word(ACT_UNUSED, 8'd5, '1, 1'b1,
                stats(ST_OK, 64'd100, 64'd100, 32'd1, 1'b0));
      // duration clamps high, then the total clamps high
      plan_word(ACT_ENTRY, 8'd6, '0, 1'b0, none);
      plan_word(ACT_EXIT, 8'd6, '1, 1'b1, stats(ST_OK, MAXS64, MAXS64, 32'd1, 1'b0));
      plan_word(ACT_ENTRY, 8'd6, '0, 1'b0, none);
      plan_word(ACT_EXIT, 8'd6, 64'd5, 1'b1, stats(ST_OK, 64'd5, MAXS64, 32'd2, 1'b0));
      // duration clamps low, then the total clamps low
      plan_word(ACT_ENTRY, 8'd7, '1, 1'b0, none);
      plan_word(ACT_EXIT, 8'd7, '0, 1'b1, stats(ST_OK, SIGN64, SIGN64, 32'd1, 1'b0));
      plan_word(ACT_ENTRY, 8'd7, 64'd10, 1'b0, none);
      plan_word(ACT_EXIT, 8'd7, '0, 1'b1,
                stats(ST_OK, 64'hFFFF_FFFF_FFFF_FFF6, SIGN64, 32'd2, 1'b0));
      // ordinary negative duration
      plan_word(ACT_ENTRY, 8'd8, 64'd1000, 1'b0, none);
      plan_word(ACT_EXIT, 8'd8, 64'd400, 1'b0, none);
      // rank_count extremes: one rank, none, and above the table size
      plan_csr(7'd1);
      plan_word(ACT_READ, 8'd0, '0, 1'b1, stats(ST_OK, '0, '0, '0, 1'b0));
      plan_word(ACT_READ, 8'd1, '0, 1'b1, stats(ST_BAD_RANK, '0, '0, '0, 1'b0));
      plan_csr(7'd0);
      plan_word(ACT_READ, 8'd0, '0, 1'b1, stats(ST_BAD_RANK, '0, '0, '0, 1'b0));
      plan_csr(7'd127);
      plan_word(ACT_READ, 8'd63, '0, 1'b1, stats(ST_OK, '0, '0, '0, 1'b0));
      plan_word(ACT_READ, 8'd64, '0, 1'b1, stats(ST_BAD_RANK, '0, '0, '0, 1'b0));
   endfunction

   function automatic logic [STAMP_W-1:0] any_stamp();
      return {$urandom, $urandom};
   endfunction

   // Random word. Mostly legal entry/exit pairs on ranks in use, so the
   // table fills with real durations; the rest is noise over every field.
   task automatic random_word(output logic [1:0] act, output logic [7:0] rk,
                              output logic [STAMP_W-1:0] ts);
      int unsigned lim;
      int unsigned pick;
      lim = ranks_in_use();
      ts  = any_stamp();
      if (lim == 0 || $urandom_range(0, 99) < 15) begin
         act = 2'($urandom_range(0, 3));
         rk  = 8'($urandom_range(0, 255));
         return;
      end
      rk   = 8'($urandom_range(0, lim - 1));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         act = $urandom_range(0, 1) ? ACT_READ : ACT_UNUSED;
      end else if (trk_active[rk]) begin
         act = (pick < 20) ? ACT_ENTRY : ACT_EXIT;
         case ($urandom_range(0, 6))
            0:       ts = any_stamp();
            1:       ts = trk_entry[rk] - 64'($urandom_range(1, 5000));
            default: ts = trk_entry[rk] + 64'($urandom_range(0, 5000));
         endcase
      end else begin
         act = (pick < 20) ? ACT_EXIT : ACT_ENTRY;
         if ($urandom_range(0, 1))
            ts = 64'($urandom_range(0, 1 << 20));
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic [CSR_W-1:0]   phase_setting [12];
      logic [1:0]         act;
      logic [7:0]         rk;
      logic [STAMP_W-1:0] ts;
      int unsigned        words;
      region_stats_type   none;

      none = '0;
      clear_tracker();
      build_directed_plan();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            drain();
            write_rank_count(directed_plan[i].csr_value);
         end else begin
            send_word(directed_plan[i].action, directed_plan[i].rank,
                      directed_plan[i].stamp, directed_plan[i].known_result,
                      directed_plan[i].result);
         end
      end

      // Random phases, each under its own rank_count. Phase 7 runs
      // without sender gaps; phase 5 pauses halfway until all is back.
      phase_setting = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd3, 7'd0, 7'd0,
                        7'd64, 7'd16, 7'd0, 7'd0, 7'd64};
      phase_setting[5]  = 7'($urandom_range(1, 127));
      phase_setting[6]  = 7'($urandom_range(0, 127));
      phase_setting[9]  = 7'($urandom_range(1, 64));
      phase_setting[10] = 7'($urandom_range(0, 127));
      for (int p = 0; p < 12; p++) begin
         drain();
         write_rank_count(phase_setting[p]);
         idle_on = (p != 7);
         words = (phase_setting[p] == 0) ? 30 : 120;
         for (int n = 0; n < words; n++) begin
            if (p == 5 && n == words / 2)
               drain();
            random_word(act, rk, ts);
            send_word(act, rk, ts, 1'b0, none);
         end
      end

      drain();
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- per_rank_region_runtime_tracker_top.f -----
+incdir+sv
sv/prrt_pkg.sv
sv/prrt_table.sv
sv/per_rank_region_runtime_tracker_top.sv
sv/prrt_checker.sv
tb/sv/per_rank_region_runtime_tracker_top_test.sv
